// File: rtl/core/hlcd_pkg.sv
`timescale 1ns / 1ps

package hlcd_pkg;

    // Frame format.
    localparam logic [7:0] HDR0       = 8'hFF;
    localparam logic [7:0] HDR1       = 8'hAA;
    localparam logic [7:0] MIN_LEN    = 8'd9;
    localparam int         LEN_POS    = 6;
    localparam int         PREFIX_LEN = 8;
    localparam logic [7:0] SUM_START  = 8'd2;

    // Configuration register indexes.
    localparam logic REG_CHECKSUM_NEG = 1'b0;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_GATHER,
        ST_DROP,
        ST_RESCAN,
        ST_RELEASE,
        ST_STREAM
    } state_t;

    // Controls for the shared checksum unit.
    typedef struct packed {
        logic clear;
        logic enable;
    } sum_ctrl_t;

endpackage

// File: rtl/core/hlcd_sum_unit.sv
`timescale 1ns / 1ps

module hlcd_sum_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hlcd_pkg::sum_ctrl_t   ctrl,
    input  logic [7:0]            pos,
    input  logic [7:0]            frame_len,
    input  logic [7:0]            data,
    input  logic                  negated,
    output logic                  match
);

    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic [7:0] stored_checksum_reg;
    logic [7:0] stored_checksum_next;
    logic       in_sum;
    logic       is_check;
    logic [7:0] want;

    // Position compares: bytes 2 to len-3 are summed, byte len-2 holds the checksum.
    assign in_sum   = (pos >= hlcd_pkg::SUM_START)
                    && (({1'b0, pos} + 9'd3) <= {1'b0, frame_len});
    assign is_check = (({1'b0, pos} + 9'd2) == {1'b0, frame_len});

    always_comb
    begin
        running_sum_next     = running_sum_reg;
        stored_checksum_next = stored_checksum_reg;
        if (ctrl.clear)
        begin
            running_sum_next     = '0;
            stored_checksum_next = '0;
        end
        else if (ctrl.enable)
        begin
            if (in_sum)
            begin
                running_sum_next = running_sum_reg + data;
            end
            if (is_check)
            begin
                stored_checksum_next = data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg     <= '0;
            stored_checksum_reg <= '0;
        end
        else
        begin
            running_sum_reg     <= running_sum_next;
            stored_checksum_reg <= stored_checksum_next;
        end
    end

    // The negated compare is done at eight bits.
    assign want  = negated ? (8'd0 - running_sum_reg) : running_sum_reg;
    assign match = (want == stored_checksum_reg);

endmodule

// File: rtl/core/header_length_checksum_deframer.sv
`timescale 1ns / 1ps

// Header, length and checksum deframer.
// Raw link bytes enter on the s_axis channel, one byte per word. The block
// hunts for the header FF AA and holds the first eight bytes of a frame;
// byte 6 is the frame length. A length of 9 or more releases the eight held
// bytes on m_axis, one per cycle, then passes each later frame byte through.
// tlast marks the final byte; tuser carries the checksum result on that word.
// A shorter length drops the header and rescans the held bytes.
// Throughput: one byte per cycle while hunting and gathering, and while
// streaming whenever the output register is free. No input is taken while
// the release feeds the prefix shift buffer out one byte per cycle through
// the checksum unit while the output register is free, or while a short
// frame is dropped and rescanned. A streamed byte appears on m_axis in the
// cycle after it is taken. When the receiver stalls, the output register
// holds its word, release waits, and s_axis_tready falls in streaming.
// Reset returns the block to hunting and clears checksum_negated; the APB
// register (address 0, bit 0) selects the negated checksum compare.
module header_length_checksum_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // is_last
    output logic [0:0]  m_axis_tuser    // [0] checksum_ok
);

    hlcd_pkg::state_t    state_reg;
    hlcd_pkg::state_t    state_next;
    logic [7:0]          store_reg [8];
    logic [7:0]          store_next [8];
    logic [3:0]          cnt_reg;
    logic [3:0]          cnt_next;
    logic [7:0]          pos_reg;
    logic [7:0]          pos_next;
    logic [7:0]          len_reg;
    logic [7:0]          len_next;
    logic                neg_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_byte_reg;
    logic [7:0]          out_byte_next;
    logic                out_last_reg;
    logic                out_last_next;
    logic                out_ok_reg;
    logic                out_ok_next;
    logic                out_free;
    logic                in_fire;
    logic                cfg_write;
    logic                sum_match;
    logic                stream_last;
    logic [7:0]          sum_data;
    hlcd_pkg::sum_ctrl_t sum_ctrl;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                     && (paddr[2] == hlcd_pkg::REG_CHECKSUM_NEG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            neg_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == hlcd_pkg::REG_CHECKSUM_NEG) ? {31'd0, neg_reg} : 32'd0;

    // Handshake helpers.
    assign out_free = !out_valid_reg || m_axis_tready;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign stream_last = ({1'b0, pos_reg} + 9'd1) >= {1'b0, len_reg};

    always_comb
    begin
        unique case (state_reg)
            hlcd_pkg::ST_HUNT,
            hlcd_pkg::ST_GATHER:  s_axis_tready = 1'b1;
            hlcd_pkg::ST_STREAM:  s_axis_tready = out_free;
            default:              s_axis_tready = 1'b0;
        endcase
    end

    // Shared checksum unit.
    hlcd_sum_unit u_sum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sum_ctrl),
        .pos       (pos_reg),
        .frame_len (len_reg),
        .data      (sum_data),
        .negated   (neg_reg),
        .match     (sum_match)
    );

    // Sequencer: next state, prefix buffer moves and output loads.
    always_comb
    begin
        state_next     = state_reg;
        store_next     = store_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_ok_next    = out_ok_reg;
        sum_ctrl       = '0;
        sum_data       = s_axis_tdata;

        unique case (state_reg)
            hlcd_pkg::ST_GATHER:
            begin
                if (in_fire)
                begin
                    store_next[cnt_reg[2:0]] = s_axis_tdata;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'(hlcd_pkg::PREFIX_LEN - 1))
                    begin
                        len_next = store_reg[hlcd_pkg::LEN_POS];
                        if (store_reg[hlcd_pkg::LEN_POS] < hlcd_pkg::MIN_LEN)
                        begin
                            state_next = hlcd_pkg::ST_DROP;
                        end
                        else
                        begin
                            state_next     = hlcd_pkg::ST_RELEASE;
                            pos_next       = '0;
                            sum_ctrl.clear = 1'b1;
                        end
                    end
                end
            end

            hlcd_pkg::ST_DROP:
            begin
                // Discard the two header bytes.
                for (int i = 0; i < hlcd_pkg::PREFIX_LEN - 2; i++)
                begin
                    store_next[i] = store_reg[i + 2];
                end
                cnt_next   = 4'(hlcd_pkg::PREFIX_LEN - 2);
                state_next = hlcd_pkg::ST_RESCAN;
            end

            hlcd_pkg::ST_RESCAN:
            begin
                // Test the front pair each cycle, then shift by one byte.
                if (cnt_reg >= 4'd2 && store_reg[0] == hlcd_pkg::HDR0
                    && store_reg[1] == hlcd_pkg::HDR1)
                begin
                    state_next = hlcd_pkg::ST_GATHER;
                end
                else if (cnt_reg <= 4'd1)
                begin
                    state_next = hlcd_pkg::ST_HUNT;
                    cnt_next   = (store_reg[0] == hlcd_pkg::HDR0) ? 4'd1 : 4'd0;
                end
                else
                begin
                    for (int i = 0; i < hlcd_pkg::PREFIX_LEN - 1; i++)
                    begin
                        store_next[i] = store_reg[i + 1];
                    end
                    cnt_next = cnt_reg - 4'd1;
                end
            end

            hlcd_pkg::ST_RELEASE:
            begin
                // Send one held byte per cycle while the output is free and feed it to the checksum unit.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = store_reg[0];
                    out_last_next   = 1'b0;
                    out_ok_next     = 1'b0;
                    sum_data        = store_reg[0];
                    sum_ctrl.enable = 1'b1;
                    for (int i = 0; i < hlcd_pkg::PREFIX_LEN - 1; i++)
                    begin
                        store_next[i] = store_reg[i + 1];
                    end
                    pos_next = pos_reg + 8'd1;
                    cnt_next = '0;
                    if (pos_reg == 8'(hlcd_pkg::PREFIX_LEN - 1))
                    begin
                        state_next = hlcd_pkg::ST_STREAM;
                    end
                end
            end

            hlcd_pkg::ST_STREAM:
            begin
                if (in_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = s_axis_tdata;
                    out_last_next   = stream_last;
                    out_ok_next     = stream_last && sum_match;
                    sum_ctrl.enable = 1'b1;
                    if (stream_last)
                    begin
                        state_next = hlcd_pkg::ST_HUNT;
                        cnt_next   = '0;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 8'd1;
                    end
                end
            end

            default:
            begin
                // Hunting for the header.
                if (in_fire)
                begin
                    if (cnt_reg == 4'd1 && s_axis_tdata == hlcd_pkg::HDR1)
                    begin
                        store_next[1] = hlcd_pkg::HDR1;
                        cnt_next      = 4'd2;
                        state_next    = hlcd_pkg::ST_GATHER;
                    end
                    else if (s_axis_tdata == hlcd_pkg::HDR0)
                    begin
                        store_next[0] = hlcd_pkg::HDR0;
                        cnt_next      = 4'd1;
                    end
                    else
                    begin
                        cnt_next = '0;
                    end
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hlcd_pkg::ST_HUNT;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        store_reg    <= store_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_ok_reg;

endmodule
